// ===== design/mhd_pkg.sv =====
package mhd_pkg;

    localparam int DATA_W       = 8;
    localparam int KIND_W       = 2;
    localparam int CFG_W        = 12;
    localparam int PAYLOAD_LIMIT = 2048;
    // payload lengths below the limit fit in this many bits
    localparam int LEN_W        = 11;
    localparam int IDX_W        = 5;

    localparam logic [IDX_W-1:0] MAGIC_BYTES   = 5'd8;
    localparam logic [IDX_W-1:0] SELF_FIRST    = 5'd12;
    localparam logic [IDX_W-1:0] SELF_LAST     = 5'd15;
    localparam logic [IDX_W-1:0] LEN_BYTE0     = 5'd16;
    localparam logic [IDX_W-1:0] LEN_BYTE1     = 5'd17;
    localparam logic [IDX_W-1:0] HEADER_LAST   = 5'd19;
    localparam logic [DATA_W-1:0] HEADER_BYTES = 8'd20;

    localparam logic [CFG_W-1:0] MAX_PAYLOAD_RESET = 12'd1600;
    localparam logic [CFG_W-1:0] LIMIT_CAP         = CFG_W'(PAYLOAD_LIMIT);

    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ILLEGAL = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [KIND_W-1:0]  kind;
        logic [DATA_W-1:0]  payload_byte;
        logic               frame_end;
    } result_t;

    function automatic logic [DATA_W-1:0] magic_byte(input logic [2:0] idx);
        logic [DATA_W-1:0] b;
        unique case (idx)
            3'd0: b = 8'h7a;
            3'd1: b = 8'h54;
            3'd2: b = 8'h85;
            3'd3: b = 8'h40;
            3'd4: b = 8'haf;
            3'd5: b = 8'h24;
            3'd6: b = 8'hd0;
            3'd7: b = 8'h24;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== design/mhd_ifs.sv =====
interface mhd_byte_if;
    import mhd_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              new_connection;

    modport source (output valid, output data_byte, output new_connection, input ready);
    modport sink   (input valid, input data_byte, input new_connection, output ready);
endinterface

interface mhd_result_if;
    import mhd_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] payload_byte;
    logic              frame_end;

    modport source (output valid, output kind, output payload_byte, output frame_end,
                    input ready);
    modport sink   (input valid, input kind, input payload_byte, input frame_end,
                    output ready);
endinterface

interface mhd_cfg_if;
    import mhd_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] max_payload;

    modport source (output valid, output max_payload, input ready);
    modport sink   (input valid, input max_payload, output ready);
endinterface

// ===== design/magic_header_frame_deframer.sv =====
// magic header frame deframer
// stream: one received byte per transfer, with new_connection marking the
//   first byte of a connection; that flag clears all parser state first
// result: at most one result per byte: a payload byte (kind 0, frame_end on
//   the last one), an empty frame (kind 1) or an illegal header (kind 2),
//   after which bytes are dropped until the next connection start
// cfg: writes max_payload; always ready, meant to be written while idle
// a 20-byte header (magic, id, self length, payload length) yields no result
//   until its last byte is checked
// a result is valid on the result channel the cycle after the byte's transfer,
//   unless the result side stalls; the single parser stage checks and counts
//   each byte as it arrives, taking one byte per cycle while stream.ready is high
// the result side has an output register plus one skid register, so with a
//   stalled receiver the deframer still takes bytes until one more result is held;
//   stream.ready drops only while the skid register is occupied
// reset: parser back to header phase, max_payload to 1600, no result pending
module magic_header_frame_deframer (
    input  logic          clk,
    input  logic          rst_n,
    mhd_byte_if.sink      stream,
    mhd_result_if.source  result,
    mhd_cfg_if.sink       cfg
);
    import mhd_pkg::*;

    logic [CFG_W-1:0] max_payload_reg;
    logic             accept;
    result_t          res_new;
    result_t          out_reg, out_next;
    result_t          skid_reg, skid_next;

    assign cfg.ready    = 1'b1;
    assign stream.ready = !skid_reg.valid;
    assign accept       = stream.valid && stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_payload_reg <= MAX_PAYLOAD_RESET;
        else if (cfg.valid && cfg.ready)
            max_payload_reg <= cfg.max_payload;
    end

    mhd_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (stream.data_byte),
        .new_connection (stream.new_connection),
        .max_payload    (max_payload_reg),
        .result         (res_new)
    );

    always_comb
    begin
        out_next  = out_reg;
        skid_next = skid_reg;
        if (result.ready || !out_reg.valid)
        begin
            // output slot frees up: older skid entry goes first
            if (skid_reg.valid)
            begin
                out_next        = skid_reg;
                skid_next.valid = 1'b0;
            end
            else
            begin
                out_next = res_new;
            end
        end
        else if (res_new.valid)
        begin
            skid_next = res_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg  <= '0;
            skid_reg <= '0;
        end
        else
        begin
            out_reg  <= out_next;
            skid_reg <= skid_next;
        end
    end

    assign result.valid        = out_reg.valid;
    assign result.kind         = out_reg.kind;
    assign result.payload_byte = out_reg.payload_byte;
    assign result.frame_end    = out_reg.frame_end;

endmodule

// ===== design/mhd_parser.sv =====
module mhd_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [mhd_pkg::DATA_W-1:0]   data_byte,
    input  logic                         new_connection,
    input  logic [mhd_pkg::CFG_W-1:0]    max_payload,
    output mhd_pkg::result_t             result
);
    import mhd_pkg::*;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_HALTED  = 2'd2;

    logic [1:0]       phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             magic_ok_reg, magic_ok_next;
    logic             self_ok_reg, self_ok_next;
    logic [LEN_W-1:0] plen_reg, plen_next;
    logic             plen_hi_reg, plen_hi_next;
    logic [LEN_W-1:0] rem_reg, rem_next;

    // state as seen by this byte, after a connection start clears it
    logic [1:0]       phase_cur;
    logic [IDX_W-1:0] idx_cur;
    logic             magic_ok_cur, self_ok_cur, plen_hi_cur;
    logic [LEN_W-1:0] plen_cur, rem_cur, rem_dec;
    logic [CFG_W-1:0] limit;
    logic             hi_final, hdr_ok;

    always_comb
    begin
        if (new_connection)
        begin
            phase_cur    = PH_HEADER;
            idx_cur      = '0;
            magic_ok_cur = 1'b1;
            self_ok_cur  = 1'b1;
            plen_cur     = '0;
            plen_hi_cur  = 1'b0;
            rem_cur      = '0;
        end
        else
        begin
            phase_cur    = phase_reg;
            idx_cur      = idx_reg;
            magic_ok_cur = magic_ok_reg;
            self_ok_cur  = self_ok_reg;
            plen_cur     = plen_reg;
            plen_hi_cur  = plen_hi_reg;
            rem_cur      = rem_reg;
        end
    end

    assign limit    = (max_payload > LIMIT_CAP) ? LIMIT_CAP : max_payload;
    assign hi_final = plen_hi_cur | (|data_byte);
    assign hdr_ok   = magic_ok_cur && self_ok_cur && !hi_final
                      && ({1'b0, plen_cur} < limit);
    assign rem_dec  = (rem_cur != '0) ? rem_cur - LEN_W'(1) : rem_cur;

    always_comb
    begin
        phase_next    = phase_cur;
        idx_next      = idx_cur;
        magic_ok_next = magic_ok_cur;
        self_ok_next  = self_ok_cur;
        plen_next     = plen_cur;
        plen_hi_next  = plen_hi_cur;
        rem_next      = rem_cur;
        result        = '0;

        unique case (phase_cur)
            PH_PAYLOAD:
            begin
                rem_next            = rem_dec;
                result.valid        = 1'b1;
                result.kind         = KIND_PAYLOAD;
                result.payload_byte = data_byte;
                if (rem_dec == '0)
                begin
                    result.frame_end = 1'b1;
                    phase_next       = PH_HEADER;
                    idx_next         = '0;
                    magic_ok_next    = 1'b1;
                    self_ok_next     = 1'b1;
                    plen_next        = '0;
                    plen_hi_next     = 1'b0;
                end
            end
            PH_HEADER:
            begin
                idx_next = idx_cur + IDX_W'(1);
                if (idx_cur < MAGIC_BYTES)
                begin
                    if (data_byte != magic_byte(idx_cur[2:0]))
                        magic_ok_next = 1'b0;
                end
                else if (idx_cur == SELF_FIRST)
                begin
                    if (data_byte != HEADER_BYTES)
                        self_ok_next = 1'b0;
                end
                else if (idx_cur > SELF_FIRST && idx_cur <= SELF_LAST)
                begin
                    if (data_byte != '0)
                        self_ok_next = 1'b0;
                end
                else if (idx_cur == LEN_BYTE0)
                begin
                    plen_next[7:0] = data_byte;
                end
                else if (idx_cur == LEN_BYTE1)
                begin
                    plen_next[LEN_W-1:8] = data_byte[LEN_W-9:0];
                    plen_hi_next         = plen_hi_cur | (|data_byte[7:LEN_W-8]);
                end
                else if (idx_cur > LEN_BYTE1 && idx_cur < HEADER_LAST)
                begin
                    plen_hi_next = plen_hi_cur | (|data_byte);
                end

                if (idx_cur == HEADER_LAST)
                begin
                    idx_next      = '0;
                    magic_ok_next = 1'b1;
                    self_ok_next  = 1'b1;
                    plen_next     = '0;
                    plen_hi_next  = 1'b0;
                    result.valid  = 1'b1;
                    if (!hdr_ok)
                    begin
                        phase_next  = PH_HALTED;
                        result.kind = KIND_ILLEGAL;
                    end
                    else if (plen_cur == '0)
                    begin
                        result.kind      = KIND_EMPTY;
                        result.frame_end = 1'b1;
                    end
                    else
                    begin
                        result.valid = 1'b0;
                        rem_next     = plen_cur;
                        phase_next   = PH_PAYLOAD;
                    end
                end
            end
            default:
            begin
                // halted and the unused code: bytes are dropped
            end
        endcase

        if (!accept)
            result.valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            idx_reg      <= '0;
            magic_ok_reg <= 1'b1;
            self_ok_reg  <= 1'b1;
            plen_reg     <= '0;
            plen_hi_reg  <= 1'b0;
            rem_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            magic_ok_reg <= magic_ok_next;
            self_ok_reg  <= self_ok_next;
            plen_reg     <= plen_next;
            plen_hi_reg  <= plen_hi_next;
            rem_reg      <= rem_next;
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import mhd_pkg::*;

    localparam int LONG_HOLD      = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    // magic bytes, first byte of the stream in the low byte
    localparam logic [63:0] FRAME_MAGIC = 64'h24d0_24af_4085_547a;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_HALTED
    } parse_phase_t;

    typedef enum int {
        BAD_MAGIC,
        BAD_HDR_SIZE,
        NEG_LEN,
        LEN_AT_LIMIT,
        LEN_HUGE
    } header_fault_t;

    typedef struct {
        logic [DATA_W-1:0] data_byte;
        logic              new_connection;
    } stream_item_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] payload_byte;
        logic              frame_end;
    } frame_result_t;

    logic clk;
    logic rst_n;

    mhd_byte_if   stream_if ();
    mhd_result_if result_if ();
    mhd_cfg_if    cfg_if ();

    magic_header_frame_deframer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    // deframer state as the testbench sees it
    parse_phase_t      prs_phase;
    logic [IDX_W-1:0]  hdr_count;
    logic              magic_ok;
    logic [31:0]       hdr_size_field;
    logic [31:0]       body_len;
    logic [LEN_W-1:0]  bytes_left;
    logic [CFG_W-1:0]  max_cfg;

    stream_item_t      pending_bytes[$];
    frame_result_t     expected_results[$];
    logic [DATA_W-1:0] frame_buf[$];

    stream_item_t  next_item;
    frame_result_t predicted;
    frame_result_t want;

    int  queued_bytes;
    int  bytes_in;
    int  errors;
    int  send_gap;
    int  sink_wait;
    int  hold_requests;
    int  holds_started;
    int  idle_cycles;
    int  cfg_writes;
    int  kind_seen[3];
    bit  sender_gaps;
    bit  sink_stalls;
    bit  need_nc;

    always #1 clk = ~clk;

    function automatic void clear_header();
        hdr_count      = '0;
        magic_ok       = 1'b1;
        hdr_size_field = '0;
        body_len       = '0;
    endfunction

    function automatic bit deframe_predict(input logic [DATA_W-1:0] b, input logic nc,
                                           output frame_result_t r);
        logic [CFG_W-1:0] cap;
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = '0;
        r.frame_end    = 1'b0;
        if (nc)
        begin
            prs_phase  = PH_HEADER;
            clear_header();
            bytes_left = '0;
        end
        if (prs_phase == PH_PAYLOAD)
        begin
            if (bytes_left != 0)
                bytes_left--;
            if (bytes_left == 0)
            begin
                prs_phase = PH_HEADER;
                clear_header();
                r.frame_end = 1'b1;
            end
            r.payload_byte = b;
            return 1'b1;
        end
        if (prs_phase != PH_HEADER)
            return 1'b0;
        if (hdr_count < 8)
        begin
            if (b != FRAME_MAGIC[8*hdr_count[2:0] +: 8])
                magic_ok = 1'b0;
        end
        else if (hdr_count >= 12 && hdr_count < 16)
            hdr_size_field[8*(hdr_count-12) +: 8] = b;
        else if (hdr_count >= 16)
            body_len[8*(hdr_count-16) +: 8] = b;
        hdr_count++;
        if (hdr_count < 20)
            return 1'b0;
        // effective limit never exceeds the payload buffer
        cap = (max_cfg > LIMIT_CAP) ? LIMIT_CAP : max_cfg;
        if (!magic_ok || hdr_size_field != 32'd20 || body_len[31]
            || body_len >= {20'd0, cap})
        begin
            prs_phase = PH_HALTED;
            r.kind    = KIND_ILLEGAL;
            return 1'b1;
        end
        if (body_len == 0)
        begin
            clear_header();
            r.kind      = KIND_EMPTY;
            r.frame_end = 1'b1;
            return 1'b1;
        end
        bytes_left = body_len[LEN_W-1:0];
        prs_phase  = PH_PAYLOAD;
        clear_header();
        return 1'b0;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 85)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // stream driver and prediction on each accepted byte
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stream_if.valid && stream_if.ready)
            begin
                bytes_in++;
                if (deframe_predict(stream_if.data_byte, stream_if.new_connection, predicted))
                    expected_results.push_back(predicted);
            end
            if (!stream_if.valid || stream_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    stream_if.valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    next_item = pending_bytes.pop_front();
                    stream_if.valid          <= 1'b1;
                    stream_if.data_byte      <= next_item.data_byte;
                    stream_if.new_connection <= next_item.new_connection;
                    send_gap = sender_gaps ? pick_gap() : 0;
                end
                else
                    stream_if.valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver backpressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (result_if.kind < 3)
                    kind_seen[result_if.kind]++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result kind=%0d byte=%02h end=%0b", $time,
                             result_if.kind, result_if.payload_byte, result_if.frame_end);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_if.kind !== want.kind
                        || result_if.payload_byte !== want.payload_byte
                        || result_if.frame_end !== want.frame_end)
                    begin
                        $display("%0t: mismatch exp %0d/%02h/%0b got %0d/%02h/%0b",
                                 $time, want.kind, want.payload_byte, want.frame_end,
                                 result_if.kind, result_if.payload_byte, result_if.frame_end);
                        errors++;
                    end
                end
            end
            if (holds_started < hold_requests)
            begin
                holds_started++;
                sink_wait = LONG_HOLD;
            end
            if (sink_wait > 0)
            begin
                sink_wait--;
                result_if.ready <= 1'b0;
            end
            else
            begin
                result_if.ready <= 1'b1;
                sink_wait = sink_stalls ? pick_gap() : 0;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready)
                || (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, no transfer for %0d cycles", $time, idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [DATA_W-1:0] b, input logic nc);
        stream_item_t it;
        it.data_byte      = b;
        it.new_connection = nc;
        pending_bytes.push_back(it);
        queued_bytes++;
    endtask

    // header (magic, id, self length, payload length) followed by payload bytes
    task automatic build_frame(input int bad_pos, input logic [31:0] self_l,
                               input logic [31:0] pay_l, input int n_payload);
        logic [DATA_W-1:0] flip;
        frame_buf.delete();
        for (int i = 0; i < 8; i++)
        begin
            flip = (i == bad_pos) ? 8'($urandom_range(1, 255)) : 8'h00;
            frame_buf.push_back(FRAME_MAGIC[8*i +: 8] ^ flip);
        end
        for (int i = 0; i < 4; i++)
            frame_buf.push_back(8'($urandom()));
        for (int i = 0; i < 4; i++)
            frame_buf.push_back(self_l[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            frame_buf.push_back(pay_l[8*i +: 8]);
        for (int i = 0; i < n_payload; i++)
            frame_buf.push_back(8'($urandom()));
    endtask

    task automatic emit_frame(input logic nc, input int keep);
        int n;
        n = (keep < 0 || keep > frame_buf.size()) ? frame_buf.size() : keep;
        for (int i = 0; i < n; i++)
            push_byte(frame_buf[i], nc && i == 0);
    endtask

    task automatic good_frame(input logic nc, input int len);
        build_frame(-1, 32'd20, 32'(len), len);
        emit_frame(nc, -1);
    endtask

    task automatic fill_random(input int n);
        int stop_at;
        int pick;
        int cap;
        int len;
        int bad_pos;
        logic nc;
        logic [31:0] self_l;
        logic [31:0] pay_l;
        header_fault_t fault;
        stop_at = queued_bytes + n;
        while (queued_bytes < stop_at)
        begin
            pick    = $urandom_range(0, 99);
            nc      = need_nc || ($urandom_range(0, 9) == 0);
            need_nc = 1'b0;
            cap     = (max_cfg > LIMIT_CAP) ? PAYLOAD_LIMIT : int'(max_cfg);
            if ($urandom_range(0, 19) == 0)
                len = $urandom_range(0, (cap - 1 < 300) ? cap - 1 : 300);
            else
                len = $urandom_range(0, (cap - 1 < 16) ? cap - 1 : 16);
            if (pick >= 70 && pick < 82)
            begin
                bad_pos = -1;
                self_l  = 32'd20;
                pay_l   = 32'(len);
                fault   = header_fault_t'($urandom_range(0, 4));
                case (fault)
                    BAD_MAGIC:    bad_pos = $urandom_range(0, 7);
                    BAD_HDR_SIZE: self_l = 32'd20 ^ (32'd1 << $urandom_range(0, 31));
                    NEG_LEN:      pay_l = 32'h8000_0000 | $urandom();
                    LEN_AT_LIMIT: pay_l = 32'(cap + $urandom_range(0, 3));
                    default:      pay_l = $urandom() | 32'h0000_1000;
                endcase
                // trailing bytes land on a halted parser
                build_frame(bad_pos, self_l, pay_l, $urandom_range(0, 6));
                emit_frame(nc, -1);
                need_nc = 1'b1;
            end
            else if (pick >= 82 && pick < 92)
            begin
                build_frame(-1, 32'd20, 32'(len), len);
                emit_frame(nc, $urandom_range(1, frame_buf.size() - 1));
                need_nc = 1'b1;
            end
            else if (pick >= 92)
            begin
                for (int i = $urandom_range(1, 8); i > 0; i--)
                    push_byte(8'($urandom()), nc && i == 1);
                need_nc = 1'b1;
            end
            else
                good_frame(nc, len);
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || stream_if.valid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_max_payload(input logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.max_payload <= v;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        max_cfg = v;
        cfg_writes++;
    endtask

    initial
    begin
        clk   = 1'b0;
        rst_n = 1'b0;
        stream_if.valid          = 1'b0;
        stream_if.data_byte      = '0;
        stream_if.new_connection = 1'b0;
        result_if.ready          = 1'b0;
        cfg_if.valid             = 1'b0;
        cfg_if.max_payload       = '0;
        prs_phase  = PH_HEADER;
        bytes_left = '0;
        max_cfg    = MAX_PAYLOAD_RESET;
        clear_header();
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        need_nc     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed frames at the reset limit
        good_frame(1'b1, 0);
        build_frame(-1, 32'd20, 32'd2, 2);
        frame_buf[20] = 8'h00;
        frame_buf[21] = 8'hff;
        emit_frame(1'b0, -1);
        good_frame(1'b0, 1);
        build_frame(-1, 32'd20, 32'd1600, 0);
        emit_frame(1'b0, -1);
        push_byte(8'h7a, 1'b0);
        push_byte(8'hff, 1'b0);
        build_frame(7, 32'd20, 32'd3, 3);
        emit_frame(1'b1, -1);
        build_frame(-1, 32'd21, 32'd0, 0);
        emit_frame(1'b1, -1);
        build_frame(-1, 32'd20, 32'hffff_ffff, 0);
        emit_frame(1'b1, -1);
        // restart in the middle of a header, then in the middle of a payload
        build_frame(-1, 32'd20, 32'd4, 4);
        emit_frame(1'b1, 11);
        build_frame(-1, 32'd20, 32'd6, 6);
        emit_frame(1'b1, 23);
        good_frame(1'b1, 2);
        wait_idle();

        // a limit of zero rejects every header
        write_max_payload(12'd0);
        good_frame(1'b1, 0);
        good_frame(1'b1, 0);
        wait_idle();

        write_max_payload(12'd1);
        good_frame(1'b1, 0);
        good_frame(1'b0, 1);
        good_frame(1'b1, 0);
        wait_idle();

        // limit beyond the payload buffer is capped
        write_max_payload(12'd4095);
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        good_frame(1'b1, 520);
        build_frame(-1, 32'd20, 32'(PAYLOAD_LIMIT), 0);
        emit_frame(1'b0, -1);
        good_frame(1'b1, 5);
        wait_idle();

        // long receiver hold while the sender keeps offering
        write_max_payload(LIMIT_CAP);
        sender_gaps = 1'b0;
        sink_stalls = 1'b1;
        fill_random(100);
        hold_requests++;
        wait_idle();
        sender_gaps = 1'b1;
        fill_random(60);
        wait_idle();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: write_max_payload(12'd1);
                1: write_max_payload(CFG_W'($urandom_range(2, 40)));
                2: write_max_payload(CFG_W'($urandom_range(41, PAYLOAD_LIMIT)));
                default: write_max_payload(MAX_PAYLOAD_RESET);
            endcase
            sender_gaps = ph[0];
            sink_stalls = (ph != 2);
            fill_random(90);
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
            errors++;
        end
        $display("covered %0d stream bytes over %0d max_payload writes, incl. limits 0 and 4095",
                 bytes_in, cfg_writes);
        $display("results: %0d payload bytes, %0d empty frames, %0d illegal headers",
                 kind_seen[0], kind_seen[1], kind_seen[2]);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
